// ===== hdl/cpsd_pkg.sv =====
package cpsd_pkg;

    localparam int SET_DEPTH  = 32;
    localparam int ID_BITS    = 16;
    localparam int ID_FIELD_W = 16;
    localparam int ID_W       = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
    localparam int PAIR_W     = 2 * ID_W;
    localparam int ADDR_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W      = $clog2(SET_DEPTH + 1);

    localparam logic [1:0] OP_INS_OLD = 2'd0;
    localparam logic [1:0] OP_INS_NEW = 2'd1;
    localparam logic [1:0] OP_DIFF    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] EV_ACK     = 2'd0;
    localparam logic [1:0] EV_REMOVED = 2'd1;
    localparam logic [1:0] EV_ADDED   = 2'd2;
    localparam logic [1:0] EV_EMPTY   = 2'd3;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [ID_FIELD_W-1:0] first_id;
        logic [ID_FIELD_W-1:0] second_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            event_kind;
        logic [ID_FIELD_W-1:0] pair_first;
        logic [ID_FIELD_W-1:0] pair_second;
        logic [1:0]            insert_status;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic              load;
        logic              clear;
        logic              rd_old;
        logic              rd_new;
        logic [ADDR_W-1:0] addr_old;
        logic [ADDR_W-1:0] addr_new;
        logic              store;
        logic              ack;
        logic [1:0]        status;
        logic              push;
        logic [1:0]        kind;
        logic              flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       in_opcode;
        logic             sel_new;
        logic             null_pair;
        logic             match;
        logic             eq;
        logic [CNT_W-1:0] old_count;
        logic [CNT_W-1:0] new_count;
    } t_status;

endpackage

// ===== hdl/cpsd_datapath.sv =====
module cpsd_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpsd_pkg::t_in_item i_item,
    input  cpsd_pkg::t_cmd     i_cmd,
    output cpsd_pkg::t_status  o_status,
    output logic               o_strobe,
    output cpsd_pkg::t_out_item o_item
);
    import cpsd_pkg::*;

    logic [PAIR_W-1:0] r_old_mem [SET_DEPTH];
    logic [PAIR_W-1:0] r_new_mem [SET_DEPTH];
    logic [PAIR_W-1:0] r_rd_old;
    logic [PAIR_W-1:0] r_rd_new;
    logic [PAIR_W-1:0] r_pair;
    logic              r_sel_new;
    logic [CNT_W-1:0]  r_old_cnt;
    logic [CNT_W-1:0]  r_new_cnt;
    logic              r_pend_valid;
    t_out_item         r_pend;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [PAIR_W-1:0] push_pair;
    t_out_item         push_item;
    t_out_item         ack_item;
    t_out_item         flush_item;
    logic [PAIR_W-1:0] rd_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !r_sel_new) begin
            r_old_mem[r_old_cnt[ADDR_W-1:0]] <= r_pair;
        end
        if (i_cmd.store && r_sel_new) begin
            r_new_mem[r_new_cnt[ADDR_W-1:0]] <= r_pair;
        end
        if (i_cmd.rd_old) begin
            r_rd_old <= r_old_mem[i_cmd.addr_old];
        end
        if (i_cmd.rd_new) begin
            r_rd_new <= r_new_mem[i_cmd.addr_new];
        end
    end

    assign push_pair = (i_cmd.kind == EV_REMOVED) ? r_rd_old : r_rd_new;
    assign rd_sel    = r_sel_new ? r_rd_new : r_rd_old;

    always_comb begin
        push_item               = '0;
        push_item.event_kind    = i_cmd.kind;
        push_item.pair_first    = ID_FIELD_W'(push_pair[PAIR_W-1:ID_W]);
        push_item.pair_second   = ID_FIELD_W'(push_pair[ID_W-1:0]);
        push_item.insert_status = ST_STORED;
        push_item.last          = 1'b0;
    end

    always_comb begin
        ack_item               = '0;
        ack_item.event_kind    = EV_ACK;
        ack_item.insert_status = i_cmd.status;
        ack_item.last          = 1'b1;
        flush_item             = '0;
        flush_item.event_kind  = EV_EMPTY;
        flush_item.last        = 1'b1;
        if (r_pend_valid) begin
            flush_item      = r_pend;
            flush_item.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pair    <= {i_item.first_id[ID_W-1:0], i_item.second_id[ID_W-1:0]};
            r_sel_new <= (i_item.opcode == OP_INS_NEW);
        end
        if (i_cmd.push) begin
            r_pend <= push_item;
        end
        if (i_cmd.ack) begin
            r_out <= ack_item;
        end else if (i_cmd.push) begin
            r_out <= r_pend;
        end else if (i_cmd.flush) begin
            r_out <= flush_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_cnt    <= '0;
            r_new_cnt    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_old_cnt <= '0;
                r_new_cnt <= '0;
            end else if (i_cmd.store) begin
                if (r_sel_new) begin
                    r_new_cnt <= CNT_W'(r_new_cnt + 1'b1);
                end else begin
                    r_old_cnt <= CNT_W'(r_old_cnt + 1'b1);
                end
            end
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            r_out_valid <= i_cmd.ack || i_cmd.flush || (i_cmd.push && r_pend_valid);
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.in_opcode = i_item.opcode;
        o_status.sel_new   = r_sel_new;
        o_status.null_pair = (r_pair[PAIR_W-1:ID_W] == '0) || (r_pair[ID_W-1:0] == '0);
        o_status.match     = (rd_sel == r_pair);
        o_status.eq        = (r_rd_old == r_rd_new);
        o_status.old_count = r_old_cnt;
        o_status.new_count = r_new_cnt;
    end

    assign o_strobe = r_out_valid;
    assign o_item   = r_out;

endmodule

// ===== hdl/cpsd_ctrl.sv =====
module cpsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  cpsd_pkg::t_status i_status,
    output cpsd_pkg::t_cmd    o_cmd
);
    import cpsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_A_OUT,
        S_A_IN,
        S_A_CMP,
        S_B_OUT,
        S_B_IN,
        S_B_CMP
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] n_i;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] n_j;
    logic [CNT_W-1:0] sel_count;

    assign sel_count = i_status.sel_new ? i_status.new_count : i_status.old_count;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_i        = '0;
                    n_j        = '0;
                    case (i_status.in_opcode)
                        OP_INS_OLD, OP_INS_NEW: n_state = S_INS_CHK;
                        OP_DIFF:                n_state = S_A_OUT;
                        default: begin
                            o_cmd.clear  = 1'b1;
                            o_cmd.ack    = 1'b1;
                            o_cmd.status = ST_STORED;
                        end
                    endcase
                end
            end
            S_INS_CHK: begin
                if (i_status.null_pair) begin
                    o_cmd.ack    = 1'b1;
                    o_cmd.status = ST_NULL;
                    n_state      = S_IDLE;
                end else if (r_j >= sel_count) begin
                    o_cmd.ack = 1'b1;
                    if (sel_count >= CNT_W'(SET_DEPTH)) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.store  = 1'b1;
                        o_cmd.status = ST_STORED;
                    end
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_old   = !i_status.sel_new;
                    o_cmd.rd_new   = i_status.sel_new;
                    o_cmd.addr_old = r_j[ADDR_W-1:0];
                    o_cmd.addr_new = r_j[ADDR_W-1:0];
                    n_state        = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_status.match) begin
                    o_cmd.ack    = 1'b1;
                    o_cmd.status = ST_PRESENT;
                    n_state      = S_IDLE;
                end else begin
                    n_j     = CNT_W'(r_j + 1'b1);
                    n_state = S_INS_CHK;
                end
            end
            S_A_OUT: begin
                if (r_i >= i_status.old_count) begin
                    n_i     = '0;
                    n_state = S_B_OUT;
                end else begin
                    o_cmd.rd_old   = 1'b1;
                    o_cmd.addr_old = r_i[ADDR_W-1:0];
                    n_j            = '0;
                    n_state        = S_A_IN;
                end
            end
            S_A_IN: begin
                if (r_j >= i_status.new_count) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = EV_REMOVED;
                    n_i        = CNT_W'(r_i + 1'b1);
                    n_state    = S_A_OUT;
                end else begin
                    o_cmd.rd_new   = 1'b1;
                    o_cmd.addr_new = r_j[ADDR_W-1:0];
                    n_state        = S_A_CMP;
                end
            end
            S_A_CMP: begin
                if (i_status.eq) begin
                    n_i     = CNT_W'(r_i + 1'b1);
                    n_state = S_A_OUT;
                end else begin
                    n_j     = CNT_W'(r_j + 1'b1);
                    n_state = S_A_IN;
                end
            end
            S_B_OUT: begin
                if (r_i >= i_status.new_count) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.rd_new   = 1'b1;
                    o_cmd.addr_new = r_i[ADDR_W-1:0];
                    n_j            = '0;
                    n_state        = S_B_IN;
                end
            end
            S_B_IN: begin
                if (r_j >= i_status.old_count) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = EV_ADDED;
                    n_i        = CNT_W'(r_i + 1'b1);
                    n_state    = S_B_OUT;
                end else begin
                    o_cmd.rd_old   = 1'b1;
                    o_cmd.addr_old = r_j[ADDR_W-1:0];
                    n_state        = S_B_CMP;
                end
            end
            S_B_CMP: begin
                if (i_status.eq) begin
                    n_i     = CNT_W'(r_i + 1'b1);
                    n_state = S_B_OUT;
                end else begin
                    n_j     = CNT_W'(r_j + 1'b1);
                    n_state = S_B_IN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/contact_pair_set_diff.sv =====
// Two bounded sets of ordered id pairs, an old set and a new set, with a diff.
// A transaction is accepted on a rising edge with start high and busy low; its
// payload is i_in_item. Insert into old, insert into new, diff and clear are
// selected by the opcode. Every result appears on o_out_item for exactly one
// cycle with o_strobe high, and the final result of a transaction has last set.
// A clear answers in the cycle after acceptance and leaves busy low.
// An insert compares the pair against the stored entries one at a time through
// the single read port of the chosen set memory, reading an entry and then
// comparing it; the acknowledgement shows in the cycle that busy falls.
// A diff runs an outer scan over the old set with an inner scan over the new set,
// then an outer scan over the new set with an inner scan over the old set.
// Each result of a diff is held one step so that the final one can carry last.
// Busy stays high until the last result is registered, so a new transaction may
// be started in the cycle that result is shown.
// Reset empties both sets and clears all control state; set memories are not
// cleared, since only entries below the counts are ever read.
// The receiver cannot stall, and results are never held back.
module contact_pair_set_diff (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cpsd_pkg::t_in_item   i_in_item,
    output logic                 o_strobe,
    output cpsd_pkg::t_out_item  o_out_item
);
    import cpsd_pkg::*;

    t_cmd    cmd;
    t_status status;

    cpsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cpsd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_item   (o_out_item)
    );

endmodule

// ===== hdl/cpsd_checker.sv =====
module cpsd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input cpsd_pkg::t_out_item o_out_item
);
    import cpsd_pkg::*;

    // An accepted transaction either keeps the block busy or answers at once.
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transaction neither busy nor answered");

    // A result that is not the last one is followed by more work.
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out_item.last) |-> busy)
        else $error("intermediate result while idle");

    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_out_item.event_kind == EV_ACK || o_out_item.event_kind == EV_EMPTY))
        |-> (o_out_item.last && o_out_item.pair_first == '0 && o_out_item.pair_second == '0))
        else $error("single result transaction malformed");

    a_diff_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_out_item.event_kind == EV_REMOVED
                      || o_out_item.event_kind == EV_ADDED))
        |-> (o_out_item.insert_status == ST_STORED && o_out_item.pair_first != '0
             && o_out_item.pair_second != '0))
        else $error("diff result carries a null pair or a status");

endmodule

bind contact_pair_set_diff cpsd_checker u_cpsd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cpsd_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TOTAL_ITEMS  = 180;
    localparam int TAIL_CYCLES  = 100;

    typedef struct packed {
        logic     drain;
        t_in_item item;
    } t_pend_item;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  in_item = '0;
    logic      o_strobe;
    t_out_item o_out_item;

    t_pend_item pending[$];
    t_out_item  exp_events[$];

    logic [PAIR_W-1:0] set_mem [2][SET_DEPTH];
    int                set_cnt [2];

    int n_total      = 0;
    int n_accepted   = 0;
    int n_exp_total  = 0;
    int n_seen_total = 0;
    int n_fail       = 0;
    int n_diffs      = 0;
    int n_full_drops = 0;
    int cycle_cnt    = 0;

    contact_pair_set_diff u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_item  (in_item),
        .o_strobe   (o_strobe),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit set_has(int sel, logic [PAIR_W-1:0] p);
        for (int i = 0; i < set_cnt[sel]; i++) begin
            if (set_mem[sel][i] == p) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_event(t_out_item r);
        exp_events.push_back(r);
        n_exp_total++;
    endtask

    task automatic predict_events(t_in_item it);
        logic [ID_W-1:0]   a;
        logic [ID_W-1:0]   b;
        logic [PAIR_W-1:0] p;
        t_out_item         r;
        t_out_item         held;
        bit                have_held;
        int                sel;
        a = it.first_id[ID_W-1:0];
        b = it.second_id[ID_W-1:0];
        p = {a, b};
        r = '0;
        have_held = 1'b0;
        held = '0;
        case (it.opcode)
            OP_INS_OLD, OP_INS_NEW: begin
                sel = (it.opcode == OP_INS_NEW) ? 1 : 0;
                if (a == '0 || b == '0) begin
                    r.insert_status = ST_NULL;
                end else if (set_has(sel, p)) begin
                    r.insert_status = ST_PRESENT;
                end else if (set_cnt[sel] >= SET_DEPTH) begin
                    r.insert_status = ST_FULL;
                    n_full_drops++;
                end else begin
                    set_mem[sel][set_cnt[sel]] = p;
                    set_cnt[sel]++;
                    r.insert_status = ST_STORED;
                end
                r.event_kind = EV_ACK;
                r.last = 1'b1;
                push_event(r);
            end
            OP_DIFF: begin
                n_diffs++;
                for (int s = 0; s < 2; s++) begin
                    for (int i = 0; i < set_cnt[s]; i++) begin
                        if (!set_has(1 - s, set_mem[s][i])) begin
                            if (have_held) push_event(held);
                            held = '0;
                            held.event_kind = (s == 1) ? EV_ADDED : EV_REMOVED;
                            held.pair_first[ID_W-1:0]  = set_mem[s][i][PAIR_W-1:ID_W];
                            held.pair_second[ID_W-1:0] = set_mem[s][i][ID_W-1:0];
                            have_held = 1'b1;
                        end
                    end
                end
                if (!have_held) held.event_kind = EV_EMPTY;
                held.last = 1'b1;
                push_event(held);
            end
            default: begin
                set_cnt[0] = 0;
                set_cnt[1] = 0;
                r.event_kind = EV_ACK;
                r.last = 1'b1;
                push_event(r);
            end
        endcase
    endtask

    function automatic int idle_pct();
        if (n_accepted < n_total / 3) return 12;
        if (n_accepted < (2 * n_total) / 3) return 81;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        bit         drained;
        bit         go;
        t_pend_item nxt;
        if (!i_rst_n) begin
            start   <= 1'b0;
            in_item <= '0;
        end else begin
            if (start && !busy) begin
                predict_events(in_item);
                n_accepted++;
            end
            if (!start || !busy) begin
                drained = (n_exp_total == n_seen_total + int'(o_strobe));
                go = (pending.size() != 0) && ($urandom_range(0, 99) >= idle_pct());
                if (go && pending[0].drain && !drained) go = 1'b0;
                start <= go;
                if (go) begin
                    nxt = pending.pop_front();
                    in_item <= nxt.item;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            n_seen_total <= n_seen_total + 1;
            if (exp_events.size() == 0) begin
                $error("unexpected result: event_kind %0h pair %0h,%0h",
                       o_out_item.event_kind, o_out_item.pair_first,
                       o_out_item.pair_second);
                n_fail++;
            end else begin
                want = exp_events.pop_front();
                compare_field("event_kind", 16'(want.event_kind), 16'(o_out_item.event_kind));
                compare_field("pair_first", want.pair_first, o_out_item.pair_first);
                compare_field("pair_second", want.pair_second, o_out_item.pair_second);
                compare_field("insert_status", 16'(want.insert_status),
                              16'(o_out_item.insert_status));
                compare_field("last", 16'(want.last), 16'(o_out_item.last));
            end
        end
    end

    task automatic queue_item(logic [1:0] op, logic [15:0] a, logic [15:0] b, bit drain);
        t_pend_item p;
        p.drain          = drain;
        p.item.opcode    = op;
        p.item.first_id  = a;
        p.item.second_id = b;
        pending.push_back(p);
    endtask

    function automatic logic [15:0] rand_id();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return 16'h0000;
        if (pick < 14) return 16'hFFFF;
        if (pick < 26) return 16'($urandom_range(0, 16'hFFFF));
        return 16'($urandom_range(1, 6));
    endfunction

    initial begin
        int          seq_i;
        int          pick;
        int          n_old;
        int          n_new;
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] old_list[$];

        queue_item(OP_INS_OLD, 16'h0000, 16'h0000, 1'b0);
        queue_item(OP_INS_OLD, 16'h0000, 16'h0005, 1'b0);
        queue_item(OP_INS_OLD, 16'h0005, 16'h0000, 1'b0);
        queue_item(OP_INS_NEW, 16'h0000, 16'hFFFF, 1'b0);
        queue_item(OP_DIFF,    16'h0000, 16'h0000, 1'b0);
        queue_item(OP_INS_OLD, 16'h0001, 16'h0002, 1'b0);
        queue_item(OP_INS_OLD, 16'h0001, 16'h0002, 1'b0);
        queue_item(OP_INS_OLD, 16'h0002, 16'h0001, 1'b0);
        queue_item(OP_INS_OLD, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_item(OP_INS_NEW, 16'h0001, 16'h0002, 1'b0);
        queue_item(OP_INS_NEW, 16'hFFFF, 16'h0001, 1'b0);
        queue_item(OP_INS_NEW, 16'hFFFF, 16'h0001, 1'b0);
        queue_item(OP_DIFF,    16'hFFFF, 16'hFFFF, 1'b0);
        queue_item(OP_INS_NEW, 16'h0002, 16'h0001, 1'b0);
        queue_item(OP_INS_NEW, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_item(OP_INS_OLD, 16'hFFFF, 16'h0001, 1'b0);
        queue_item(OP_DIFF,    16'h1234, 16'h5678, 1'b0);
        queue_item(OP_CLEAR,   16'hFFFF, 16'hFFFF, 1'b0);
        queue_item(OP_DIFF,    16'h0000, 16'h0000, 1'b0);
        queue_item(OP_INS_NEW, 16'hAAAA, 16'h5555, 1'b0);
        queue_item(OP_INS_OLD, 16'h5555, 16'hAAAA, 1'b0);
        queue_item(OP_DIFF,    16'h0000, 16'h0000, 1'b0);
        queue_item(OP_CLEAR,   16'h0000, 16'h0000, 1'b0);

        seq_i = 0;
        while (pending.size() < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (seq_i == 2) begin
                queue_item(OP_CLEAR, rand_id(), rand_id(), 1'b0);
                for (int k = 0; k < SET_DEPTH + 2; k++) begin
                    queue_item(OP_INS_OLD, 16'(k + 1), 16'($urandom_range(1, 3)), 1'b0);
                end
                for (int k = 0; k < SET_DEPTH + 2; k++) begin
                    queue_item(OP_INS_NEW, 16'(k + SET_DEPTH + 1),
                               16'($urandom_range(1, 3)), 1'b0);
                end
                queue_item(OP_DIFF, rand_id(), rand_id(), 1'b1);
            end else if (pick < 80) begin
                if ($urandom_range(0, 4) != 0) queue_item(OP_CLEAR, rand_id(), rand_id(), 1'b0);
                old_list.delete();
                n_old = $urandom_range(0, 6);
                for (int k = 0; k < n_old; k++) begin
                    a = rand_id();
                    b = rand_id();
                    if (k > 0 && $urandom_range(0, 5) == 0) {a, b} = old_list[old_list.size() - 1];
                    old_list.push_back({a, b});
                    queue_item(OP_INS_OLD, a, b, 1'b0);
                end
                n_new = $urandom_range(0, 6);
                for (int k = 0; k < n_new; k++) begin
                    if (old_list.size() > 0 && $urandom_range(0, 1) == 1) begin
                        {a, b} = old_list[$urandom_range(0, old_list.size() - 1)];
                    end else begin
                        a = rand_id();
                        b = rand_id();
                    end
                    queue_item(OP_INS_NEW, a, b, 1'b0);
                end
                queue_item(OP_DIFF, rand_id(), rand_id(),
                           (seq_i == 0) || ($urandom_range(0, 9) == 0));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    queue_item(2'($urandom_range(0, 3)), rand_id(), rand_id(), 1'b0);
                end
            end
            seq_i++;
        end
        n_total = pending.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (n_accepted < n_total || n_exp_total != n_seen_total) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (exp_events.size() != 0) begin
            $error("%0d expected results never arrived", exp_events.size());
            n_fail++;
        end
        $display("Ran %0d transactions (%0d diffs), checked %0d results.",
                 n_accepted, n_diffs, n_seen_total);
        $display("Inserts dropped on a full set: %0d; cycles used: %0d.",
                 n_full_drops, cycle_cnt);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
